/* hw/rtl/rlc_pkg.sv */
// Shared types and constants for the byte run-length codec.
`timescale 1ns / 1ps
package rlc_pkg;

  typedef enum logic [0:0] {
    MODE_COMPRESS = 1'b0,
    MODE_EXPAND   = 1'b1
  } mode_t;

  typedef enum logic [0:0] {
    CMD_EMIT   = 1'b0,
    CMD_EXPAND = 1'b1
  } cmd_kind_t;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } rlc_in_t;

  typedef struct packed {
    logic [31:0] out_data;
    logic [2:0]  out_count;
    logic        run_last;
  } rlc_out_t;

  // Work for the back end: either a ready packed word of pairs, or a run to expand.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic [7:0]  value;
    logic [7:0]  count;
  } rlc_cmd_t;

endpackage

/* hw/rtl/byte_rle_codec.sv */
// Top level of the byte run-length codec: front end, command queue and back end.
// The codec works in one of two modes, set by the one-bit mode register (reset to
// compress). In compress mode every input beat carries one raw byte; the block keeps
// the current byte and its run length, capped at RUN_LIMIT, and emits a
// (count, value) pair, count in the low byte, whenever the byte changes or the cap
// is hit. A beat flagged end_of_stream also flushes the open run, so a single
// result carries two or four bytes, and the run state is cleared. In expand mode
// the input beats are (count, value) byte pairs; each pair becomes count copies of
// value, packed four bytes to a result word low byte first, with run_last set on
// the final word of the pair. A zero count produces nothing, and a count byte that
// arrives with end_of_stream is dropped. Writing the mode register discards any
// partly built run or pair, and should only be done with the codec idle.
// Throughput: the front end takes one beat per cycle as long as its two-entry
// command queue has room. In compress mode that sustains one byte per cycle. In
// expand mode a pair costs two input beats and its back-end command yields
// ceil(count/4) packed words, one per cycle, so long runs hold the input off
// once the queue fills. Output stall backs up into the queue and, once
// the queue is full, holds the input off as well.
`timescale 1ns / 1ps
module byte_rle_codec #(
  parameter int unsigned RUN_LIMIT = 255
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  rlc_pkg::rlc_in_t in_beat,
  output logic             out_valid,
  input  logic             out_stall,
  output rlc_pkg::rlc_out_t out_beat
);
  import rlc_pkg::*;

  logic     accept;
  logic     push, pop, q_full, head_valid;
  rlc_cmd_t push_cmd, head_cmd;

  // The queue only pushes when it has room, so the front end stalls on queue full.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  rlc_front #(
    .RUN_LIMIT(RUN_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .beat     (in_beat),
    .push     (push),
    .cmd      (push_cmd)
  );

  rlc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  rlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  // Every result word carries between one and four bytes.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.out_count != 3'd0 && out_beat.out_count <= 3'd4))
    else $error("result byte count out of range");

  // Bytes above the valid count of a one-byte result are always zero.
  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.out_count == 3'd1) |-> (out_beat.out_data[31:8] == 24'd0))
    else $error("nonzero data above a one-byte result");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The queue never accepts work while full, so a push never coincides with in_stall.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (push && q_full) |-> 1'b0)
    else $error("command pushed into a full queue");

endmodule

/* hw/rtl/rlc_front.sv */
// Front end: takes input beats, tracks run and pair state, and issues commands.
`timescale 1ns / 1ps
module rlc_front #(
  parameter int unsigned RUN_LIMIT = 255
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             accept,
  input  rlc_pkg::rlc_in_t beat,
  output logic             push,
  output rlc_pkg::rlc_cmd_t cmd
);
  import rlc_pkg::*;

  localparam logic [7:0] LIMIT = 8'(RUN_LIMIT);

  mode_t      mode_r;
  logic [7:0] held_r, held_nxt;
  logic [7:0] run_r, run_nxt;
  logic       have_r, have_nxt;

  always_comb begin
    logic [31:0] w;
    logic [2:0]  nb;
    w        = '0;
    nb       = '0;
    held_nxt = held_r;
    run_nxt  = run_r;
    have_nxt = have_r;
    push     = 1'b0;
    cmd      = '0;
    if (accept) begin
      if (mode_r == MODE_COMPRESS) begin
        if (!have_r) begin
          held_nxt = beat.in_byte;
          run_nxt  = 8'd1;
          have_nxt = 1'b1;
        end else if (beat.in_byte == held_r && run_r < LIMIT) begin
          run_nxt = run_r + 8'd1;
        end else begin
          w[15:0]  = {held_r, run_r};
          nb       = 3'd2;
          held_nxt = beat.in_byte;
          run_nxt  = 8'd1;
        end
        if (beat.end_of_stream) begin
          if (nb == 3'd2) begin
            w[31:16] = {held_nxt, run_nxt};
          end else begin
            w[15:0] = {held_nxt, run_nxt};
          end
          nb       = nb + 3'd2;
          held_nxt = '0;
          run_nxt  = '0;
          have_nxt = 1'b0;
        end
        push       = (nb != 3'd0);
        cmd.kind   = CMD_EMIT;
        cmd.word   = w;
        cmd.nbytes = nb;
      end else begin
        if (!have_r) begin
          if (!beat.end_of_stream) begin
            run_nxt  = beat.in_byte;
            have_nxt = 1'b1;
          end else begin
            held_nxt = '0;
            run_nxt  = '0;
          end
        end else begin
          // A zero count gives nothing at all.
          push      = (run_r != 8'd0);
          cmd.kind  = CMD_EXPAND;
          cmd.value = beat.in_byte;
          cmd.count = run_r;
          held_nxt  = '0;
          run_nxt   = '0;
          have_nxt  = 1'b0;
        end
      end
    end
    if (cfg_we) begin
      held_nxt = '0;
      run_nxt  = '0;
      have_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_COMPRESS;
      held_r <= '0;
      run_r  <= '0;
      have_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= mode_t'(cfg_wdata);
      end
      held_r <= held_nxt;
      run_r  <= run_nxt;
      have_r <= have_nxt;
    end
  end

endmodule

/* hw/rtl/rlc_fifo.sv */
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module rlc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rlc_pkg::rlc_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output rlc_pkg::rlc_cmd_t head_cmd
);
  import rlc_pkg::*;

  rlc_cmd_t           mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/rlc_back.sv */
// Back end: runs one command at a time and drives the registered output beat.
`timescale 1ns / 1ps
module rlc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  rlc_pkg::rlc_cmd_t head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output rlc_pkg::rlc_out_t out_beat
);
  import rlc_pkg::*;

  logic        job_active_r;
  cmd_kind_t   job_kind_r;
  logic [31:0] job_word_r;
  logic [2:0]  job_nbytes_r;
  logic [7:0]  job_value_r;
  logic [7:0]  job_left_r, job_left_nxt;

  logic        out_valid_r;
  rlc_out_t    out_beat_r, out_beat_nxt;

  logic        out_free, emit, emit_last;
  logic [2:0]  lanes;
  logic [31:0] exp_data;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = job_active_r && out_free;
  assign lanes    = (job_left_r >= 8'd4) ? 3'd4 : job_left_r[2:0];
  assign emit_last = (job_kind_r == CMD_EMIT) || (job_left_r <= 8'd4);
  assign pop      = head_valid && (!job_active_r || (emit && emit_last));
  assign job_left_nxt = job_left_r - 8'(lanes);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      exp_data[8*i +: 8] = (3'(i) < lanes) ? job_value_r : 8'd0;
    end
    out_beat_nxt.run_last = emit_last;
    if (job_kind_r == CMD_EMIT) begin
      out_beat_nxt.out_data  = job_word_r;
      out_beat_nxt.out_count = job_nbytes_r;
    end else begin
      out_beat_nxt.out_data  = exp_data;
      out_beat_nxt.out_count = lanes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_active_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        job_active_r <= 1'b1;
      end else if (emit && emit_last) begin
        job_active_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_kind_r   <= head_cmd.kind;
      job_word_r   <= head_cmd.word;
      job_nbytes_r <= head_cmd.nbytes;
      job_value_r  <= head_cmd.value;
      job_left_r   <= head_cmd.count;
    end else if (emit) begin
      job_left_r <= job_left_nxt;
    end
    if (emit) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

/* tb/sv/testbench.sv */
// Self-checking regression for the byte run-length codec in both of its modes.
`timescale 1ns / 1ps
module testbench;
  import rlc_pkg::*;

  // The block is built with its default run cap; the predictor uses the same number.
  localparam int unsigned RUN_LIMIT = 255;
  // Chance, in percent, that either side idles on a given cycle.
  localparam int unsigned IDLE_PCT = 35;
  // Cycles the receiver refuses results in the one long hold-off.
  localparam int unsigned HOLD_CYCLES = 150;
  // Quiet cycles after the last result before the mode register is touched.
  localparam int unsigned SETTLE_CYCLES = 16;
  // Only this many mismatches are printed in full; the rest are only counted.
  localparam int unsigned MAX_REPORTS = 10;

  // The scoreboard keeps its own copy of the codec state. Each accepted input beat
  // is turned into the result beats it must cause. Each accepted result beat is
  // compared against the oldest of those.
  class codec_scoreboard;
    mode_t       mode;
    logic [7:0]  held_byte;
    logic [7:0]  run_length;
    bit          have_held;
    rlc_out_t    pending_words[$];
    int unsigned fail_count;
    int unsigned result_count;

    function void clear_stream();
      held_byte  = 8'h00;
      run_length = 8'h00;
      have_held  = 1'b0;
    endfunction

    function void reset_state();
      mode = MODE_COMPRESS;
      clear_stream();
      pending_words.delete();
      fail_count   = 0;
      result_count = 0;
    endfunction

    // Any write of the mode register throws away a partly built run or pair.
    function void write_mode(mode_t m);
      mode = m;
      clear_stream();
    endfunction

    function void note_beat(rlc_in_t beat);
      logic [31:0] word;
      logic [31:0] fill;
      int unsigned nbytes;
      int unsigned left;
      int unsigned lanes;
      word   = '0;
      nbytes = 0;
      if (mode == MODE_COMPRESS) begin
        // A byte either opens a run, extends it, or closes it and opens the next.
        if (!have_held) begin
          held_byte  = beat.in_byte;
          run_length = 8'd1;
          have_held  = 1'b1;
        end else if (beat.in_byte == held_byte && run_length < 8'(RUN_LIMIT)) begin
          run_length = run_length + 8'd1;
        end else begin
          word[7:0]  = run_length;
          word[15:8] = held_byte;
          nbytes     = 2;
          held_byte  = beat.in_byte;
          run_length = 8'd1;
        end
        // End of stream flushes the open run behind whatever pair came out above.
        if (beat.end_of_stream) begin
          word[8*nbytes +: 8]     = run_length;
          word[8*nbytes + 8 +: 8] = held_byte;
          nbytes                  = nbytes + 2;
          clear_stream();
        end
        if (nbytes != 0)
          pending_words.push_back('{out_data: word, out_count: 3'(nbytes), run_last: 1'b1});
      end else begin
        // The first byte of a pair is the count. A count that ends the stream is
        // dropped along with the pair it started.
        if (!have_held) begin
          if (beat.end_of_stream) begin
            clear_stream();
          end else begin
            run_length = beat.in_byte;
            have_held  = 1'b1;
          end
          return;
        end
        fill = {4{beat.in_byte}};
        left = 32'(run_length);
        while (left > 0) begin
          lanes = (left < 4) ? left : 4;
          left  = left - lanes;
          word  = fill & (32'hFFFF_FFFF >> (8 * (4 - lanes)));
          pending_words.push_back('{out_data: word, out_count: 3'(lanes),
                                    run_last: (left == 0)});
        end
        clear_stream();
      end
    endfunction

    function void check_result(rlc_out_t got);
      rlc_out_t want;
      result_count++;
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with nothing expected: data %h count %0d last %0b",
                   $realtime, got.out_data, got.out_count, got.run_last);
        return;
      end
      want = pending_words.pop_front();
      if (got.out_data !== want.out_data || got.out_count !== want.out_count ||
          got.run_last !== want.run_last) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display({"%0t: result %0d mismatch: expected data %h count %0d last %0b,",
                    " got data %h count %0d last %0b"},
                   $realtime, result_count, want.out_data, want.out_count, want.run_last,
                   got.out_data, got.out_count, got.run_last);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we = 1'b0;
  logic     cfg_wdata = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rlc_in_t  in_beat = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rlc_out_t out_beat;

  codec_scoreboard sb = new;

  // When calm is set neither side idles; this gives the stretch at full rate.
  bit          calm = 1'b0;
  // The main process asks for a long receiver hold-off by bumping hold_asked.
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned beats_sent = 0;

  byte_rle_codec #(
    .RUN_LIMIT(RUN_LIMIT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  always #10 clk = ~clk;

  // All sampling happens here, at the rising edge, on values that were settled
  // before it. A register write, an accepted input beat and an accepted result beat
  // are handled in that order, so a result that shows up on the same edge as the
  // beat causing it still finds its expectation in place.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we)
        sb.write_mode(mode_t'(cfg_wdata));
      if (in_valid && !in_stall)
        sb.note_beat(in_beat);
      if (out_valid && !out_stall)
        sb.check_result(out_beat);
    end
  end

  // Receiver. It stalls at random, except while calm, and serves a requested
  // hold-off by refusing every result in one unbroken stretch as long as HOLD_CYCLES.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Offers one beat, possibly after some idle cycles, and returns at the edge
  // where the block takes it. valid stays high afterwards; the next call either
  // drops it for a gap or puts the next beat up in the same step.
  task automatic send_beat(input logic [7:0] b, input logic eos);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{in_byte: b, end_of_stream: eos};
    do
      @(posedge clk);
    while (in_stall !== 1'b0);
    beats_sent++;
  endtask

  // Stops offering and waits until every expected result has come back. With
  // settle set it also waits out the beats that cause no result, so the block is
  // idle afterwards and the mode register may be written.
  task automatic wait_for_results(input bit settle);
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (sb.pending_words.size() != 0);
    if (settle)
      repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_pair(input logic [7:0] count, input logic [7:0] value,
                           input logic eos);
    send_beat(count, 1'b0);
    send_beat(value, eos);
  endtask

  // A raw byte stream made of runs. Run lengths are mostly short, sometimes a few
  // dozen bytes; a run often repeats the byte of the one before, so that two runs
  // merge. A forced length gives a single run of that length closed by end of
  // stream. Some streams are left open and run into the next.
  task automatic send_raw_stream(input int unsigned forced_len);
    int unsigned runs;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  value;
    logic [7:0]  prev;
    bit          close;
    runs  = (forced_len != 0) ? 1 : $urandom_range(1, 4);
    close = (forced_len != 0) || ($urandom_range(0, 9) != 0);
    prev  = 8'($urandom);
    for (int r = 0; r < runs; r++) begin
      pick  = $urandom_range(0, 99);
      value = (pick < 25) ? prev : 8'($urandom);
      pick  = $urandom_range(0, 99);
      if (forced_len != 0)
        len = forced_len;
      else if (pick < 70)
        len = $urandom_range(1, 5);
      else if (pick < 90)
        len = $urandom_range(6, 30);
      else
        len = $urandom_range(31, 60);
      for (int i = 0; i < len; i++)
        send_beat(value, close && r == runs - 1 && i == len - 1);
      prev = value;
    end
  endtask

  // A compressed stream. Most are well formed pair sequences with random counts
  // and values; a few end on a lone count byte, a few stay open, and a few are
  // plain noise with end of stream scattered anywhere.
  task automatic send_pair_stream();
    int unsigned kind;
    int unsigned pairs;
    int unsigned pick;
    logic [7:0]  count;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 8))
        send_beat(8'($urandom), $urandom_range(0, 5) == 0);
      return;
    end
    pairs = $urandom_range(1, 5);
    for (int p = 0; p < pairs; p++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        count = 8'd0;
      else if (pick < 60)
        count = 8'($urandom_range(1, 9));
      else if (pick < 80)
        count = 8'($urandom_range(10, 40));
      else if (pick < 95)
        count = 8'($urandom);
      else
        count = 8'd255;
      send_pair(count, 8'($urandom), kind != 2 && kind != 1 && p == pairs - 1);
    end
    // Odd trailing byte: the stream ends on a count with no value after it.
    if (kind == 1)
      send_beat(8'($urandom), 1'b1);
  endtask

  task automatic run_random_phase(input mode_t m, input int unsigned goal);
    int unsigned stop_at;
    stop_at = beats_sent + goal;
    while (beats_sent < stop_at) begin
      if (m == MODE_COMPRESS)
        send_raw_stream(0);
      else
        send_pair_stream();
      // Now and then the sender waits for the block to empty in mid-stream.
      if ($urandom_range(0, 9) == 0)
        wait_for_results(1'b0);
    end
    wait_for_results(1'b1);
  endtask

  initial begin
    sb.reset_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Compress, directed. Streams of one byte, a plain run, a change right at end
    // of stream, and a run that a mode write throws away.
    write_mode(MODE_COMPRESS);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h12, 1'b0);
    send_beat(8'h34, 1'b1);
    send_beat(8'hA5, 1'b0);
    send_beat(8'hA5, 1'b0);
    send_beat(8'h5A, 1'b0);
    send_beat(8'h5A, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h77, 1'b0);
    send_beat(8'h77, 1'b0);
    wait_for_results(1'b1);
    write_mode(MODE_COMPRESS);
    send_beat(8'h77, 1'b1);
    wait_for_results(1'b1);

    // Expand, directed. A zero count, counts of one, four, five, eight and the
    // largest, a count that ends the stream, and a held count lost to a mode write.
    write_mode(MODE_EXPAND);
    send_pair(8'd0, 8'h55, 1'b0);
    send_pair(8'd1, 8'hAB, 1'b0);
    send_pair(8'd4, 8'h00, 1'b0);
    send_pair(8'd5, 8'hFF, 1'b0);
    send_pair(8'd8, 8'h11, 1'b0);
    send_pair(8'd255, 8'h3C, 1'b0);
    send_beat(8'd7, 1'b1);
    send_pair(8'd3, 8'h81, 1'b1);
    send_beat(8'd9, 1'b0);
    wait_for_results(1'b1);
    write_mode(MODE_EXPAND);
    send_pair(8'd2, 8'h42, 1'b1);
    wait_for_results(1'b1);

    // Compress, random. It opens with a run one byte longer than the cap, so the
    // run hits the cap and its last byte starts a new run.
    write_mode(MODE_COMPRESS);
    send_raw_stream(RUN_LIMIT + 1);
    run_random_phase(MODE_COMPRESS, 20);

    // Expand, random, opening with long runs against a receiver that holds off,
    // so the command queue fills and the input is stalled.
    write_mode(MODE_EXPAND);
    hold_asked <= hold_asked + 1;
    repeat (4) send_pair(8'd255, 8'($urandom), 1'b0);
    run_random_phase(MODE_EXPAND, 30);

    // The same two modes again at full rate, with no idling on either side.
    calm <= 1'b1;
    write_mode(MODE_COMPRESS);
    run_random_phase(MODE_COMPRESS, 10);
    write_mode(MODE_EXPAND);
    run_random_phase(MODE_EXPAND, 15);
    calm <= 1'b0;

    wait_for_results(1'b1);
    if (sb.fail_count == 0 && sb.pending_words.size() == 0) begin
      $display("byte_rle_codec regression: pass");
    end else begin
      $display("byte_rle_codec regression: fail");
    end
    $finish;
  end

  // Watchdog for a block that hangs or loses results.
  initial begin
    #10ms;
    $display("byte_rle_codec regression: fail");
    $finish;
  end

endmodule
